// ----- rtl/core/deqs_pkg.sv -----
package deqs_pkg;

    // default sizing
    localparam int DEPTH_DEF      = 16;
    localparam int DATA_WIDTH_DEF = 32;

    // action codes
    localparam logic [2:0] ACT_PUSH_FRONT = 3'd0;
    localparam logic [2:0] ACT_PUSH_BACK  = 3'd1;
    localparam logic [2:0] ACT_POP_FRONT  = 3'd2;
    localparam logic [2:0] ACT_POP_BACK   = 3'd3;
    localparam logic [2:0] ACT_SEARCH     = 3'd4;

    // status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [2:0]  action;
        logic [31:0] value;
    } deqs_in_t;

    typedef struct packed {
        logic [31:0] result_value;
        logic        found;
        logic [1:0]  status;
        logic [4:0]  count;
    } deqs_out_t;

    // controller -> datapath
    typedef struct packed {
        logic load;         // capture request beat
        logic exec;         // apply push/pop, start search
        logic scan;         // search step
        logic result_load;  // move result into output register
    } deqs_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic is_search;
        logic scan_done;
        logic out_free;
    } deqs_stat_t;

endpackage

// ----- rtl/core/deqs_ctrl.sv -----
module deqs_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_stall,
    input  deqs_pkg::deqs_stat_t stat,
    output deqs_pkg::deqs_cmd_t  cmd
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_EXEC   = 2'd1;
    localparam logic [1:0] S_SCAN   = 2'd2;
    localparam logic [1:0] S_RESULT = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        req_stall  = 1'b1;
        case (state_reg)
            S_IDLE:
            begin
                req_stall = 1'b0;
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = stat.is_search ? S_SCAN : S_RESULT;
            end
            S_SCAN:
            begin
                cmd.scan = 1'b1;
                if (stat.scan_done)
                begin
                    state_next = S_RESULT;
                end
            end
            S_RESULT:
            begin
                if (stat.out_free)
                begin
                    cmd.result_load = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ----- rtl/core/deqs_datapath.sv -----
module deqs_datapath
#(
    parameter int DEPTH      = deqs_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = deqs_pkg::DATA_WIDTH_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  deqs_pkg::deqs_in_t   req,
    input  deqs_pkg::deqs_cmd_t  cmd,
    output deqs_pkg::deqs_stat_t stat,
    output logic                 rsp_valid,
    input  logic                 rsp_stall,
    output deqs_pkg::deqs_out_t  rsp
);

    localparam int AW  = $clog2(DEPTH);
    localparam int CW  = $clog2(DEPTH + 1);
    localparam int XW  = (DATA_WIDTH > 32) ? DATA_WIDTH : 32;
    localparam int CXW = (CW > 5) ? CW : 5;

    localparam logic [AW:0]   DEPTH_X = (AW + 1)'(DEPTH);
    localparam logic [AW-1:0] LAST_IX = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CT = CW'(DEPTH);

    logic [DATA_WIDTH-1:0] entry_mem [DEPTH];
    logic [DATA_WIDTH-1:0] rd_data_reg;

    logic [2:0]            act_reg;
    logic [DATA_WIDTH-1:0] word_reg;
    logic [AW-1:0]         fp_reg, fp_next;
    logic [CW-1:0]         count_reg, count_next;
    logic [CW-1:0]         idx_reg, idx_next;
    logic                  rd_valid_reg, rd_valid_next;
    logic                  hit_reg, hit_next;
    logic                  pop_ok_reg, pop_ok_next;
    logic [1:0]            status_reg, status_next;
    logic                  out_valid_reg, out_valid_next;
    deqs_pkg::deqs_out_t   out_reg;

    logic [XW-1:0]         value_ext;
    logic [XW-1:0]         res_ext;
    logic [CXW-1:0]        count_ext;
    logic [DATA_WIDTH-1:0] res_word;

    logic                  full, empty;
    logic [CW-1:0]         count_m1;
    logic [AW-1:0]         offset;
    logic [AW:0]           ring_sum;
    logic [AW:0]           ring_mod;
    logic [AW-1:0]         ring_addr;
    logic [AW-1:0]         fp_dec, fp_inc;
    logic                  match_now, issued_all;

    logic                  wr_en, rd_en;
    logic [AW-1:0]         wr_addr, rd_addr;

    assign value_ext = XW'(req.value);

    assign full     = (count_reg == FULL_CT);
    assign empty    = (count_reg == '0);
    assign count_m1 = count_reg - CW'(1);

    // ring address unit: front pointer plus an offset below DEPTH
    always_comb
    begin
        if (cmd.scan)
        begin
            offset = idx_reg[AW-1:0];
        end
        else if (act_reg == deqs_pkg::ACT_POP_BACK)
        begin
            offset = count_m1[AW-1:0];
        end
        else
        begin
            offset = count_reg[AW-1:0];
        end
    end

    assign ring_sum  = {1'b0, fp_reg} + {1'b0, offset};
    assign ring_mod  = (ring_sum >= DEPTH_X) ? (ring_sum - DEPTH_X) : ring_sum;
    assign ring_addr = ring_mod[AW-1:0];
    assign fp_dec    = (fp_reg == '0) ? LAST_IX : (fp_reg - AW'(1));
    assign fp_inc    = (fp_reg == LAST_IX) ? '0 : (fp_reg + AW'(1));

    assign match_now  = rd_valid_reg && (rd_data_reg == word_reg);
    assign issued_all = (idx_reg == count_reg);

    always_comb
    begin
        fp_next       = fp_reg;
        count_next    = count_reg;
        idx_next      = idx_reg;
        rd_valid_next = rd_valid_reg;
        hit_next      = hit_reg;
        pop_ok_next   = pop_ok_reg;
        status_next   = status_reg;
        wr_en         = 1'b0;
        rd_en         = 1'b0;
        wr_addr       = ring_addr;
        rd_addr       = ring_addr;

        if (cmd.exec)
        begin
            idx_next      = '0;
            rd_valid_next = 1'b0;
            hit_next      = 1'b0;
            pop_ok_next   = 1'b0;
            status_next   = deqs_pkg::ST_OK;
            case (act_reg)
                deqs_pkg::ACT_PUSH_FRONT:
                begin
                    if (full)
                    begin
                        status_next = deqs_pkg::ST_FULL;
                    end
                    else
                    begin
                        wr_en      = 1'b1;
                        wr_addr    = fp_dec;
                        fp_next    = fp_dec;
                        count_next = count_reg + CW'(1);
                    end
                end
                deqs_pkg::ACT_PUSH_BACK:
                begin
                    if (full)
                    begin
                        status_next = deqs_pkg::ST_FULL;
                    end
                    else
                    begin
                        wr_en      = 1'b1;
                        count_next = count_reg + CW'(1);
                    end
                end
                deqs_pkg::ACT_POP_FRONT:
                begin
                    if (empty)
                    begin
                        status_next = deqs_pkg::ST_EMPTY;
                    end
                    else
                    begin
                        rd_en       = 1'b1;
                        rd_addr     = fp_reg;
                        fp_next     = fp_inc;
                        count_next  = count_m1;
                        pop_ok_next = 1'b1;
                    end
                end
                deqs_pkg::ACT_POP_BACK:
                begin
                    if (empty)
                    begin
                        status_next = deqs_pkg::ST_EMPTY;
                    end
                    else
                    begin
                        rd_en       = 1'b1;
                        count_next  = count_m1;
                        pop_ok_next = 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end
        else if (cmd.scan)
        begin
            // read of entry idx overlaps compare of entry idx-1
            if (match_now)
            begin
                hit_next = 1'b1;
            end
            rd_en         = !match_now && !issued_all;
            rd_valid_next = rd_en;
            if (rd_en)
            begin
                idx_next = idx_reg + CW'(1);
            end
        end
    end

    assign stat.is_search = (act_reg == deqs_pkg::ACT_SEARCH);
    assign stat.scan_done = match_now || (issued_all && !rd_valid_reg);
    assign stat.out_free  = !out_valid_reg || !rsp_stall;

    always_comb
    begin
        if (pop_ok_reg)
        begin
            res_word = rd_data_reg;
        end
        else if (hit_reg)
        begin
            res_word = word_reg;
        end
        else
        begin
            res_word = '0;
        end
    end

    assign res_ext   = XW'(res_word);
    assign count_ext = CXW'(count_reg);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.result_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !rsp_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            entry_mem[wr_addr] <= word_reg;
        end
        if (rd_en)
        begin
            rd_data_reg <= entry_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            act_reg  <= req.action;
            word_reg <= value_ext[DATA_WIDTH-1:0];
        end
        idx_reg      <= idx_next;
        rd_valid_reg <= rd_valid_next;
        hit_reg      <= hit_next;
        pop_ok_reg   <= pop_ok_next;
        status_reg   <= status_next;
        if (cmd.result_load)
        begin
            out_reg.result_value <= res_ext[31:0];
            out_reg.found        <= hit_reg;
            out_reg.status       <= status_reg;
            out_reg.count        <= count_ext[4:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fp_reg        <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            fp_reg        <= fp_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

endmodule

// ----- rtl/core/double_ended_queue_with_search.sv -----
// Double-ended queue of DATA_WIDTH-bit words with a front-to-back search.
//
// Request channel (req_valid / req_stall / req): one beat carries an action
// (push front, push back, pop front, pop back, search) and a word. Response
// channel (rsp_valid / rsp_stall / rsp): exactly one beat per request, in
// order, with the popped or found word, a found flag, a status code (ok,
// pop on empty, push on full dropped) and the entry count afterwards.
//
// Requests are handled one at a time by a small sequencer. A push, pop or
// unused action steps through capture, execute and result load; the next
// request is taken the cycle after. A search walks the ring from the front
// through the single store read port with a registered read, one entry per
// cycle, and stops at the first hit or after the last held entry.
//
// Reset (rst_n, asynchronous) empties the queue: front pointer and count go
// to zero, no response pending. Store contents are not cleared.
// A stalled response sits in the output register; the next request is still
// accepted and processed, and waits only at the point of loading its result.
module double_ended_queue_with_search
#(
    parameter int DEPTH      = deqs_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = deqs_pkg::DATA_WIDTH_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_stall,
    input  deqs_pkg::deqs_in_t  req,
    output logic                rsp_valid,
    input  logic                rsp_stall,
    output deqs_pkg::deqs_out_t rsp
);

    deqs_pkg::deqs_cmd_t  cmd;
    deqs_pkg::deqs_stat_t stat;

    // sequencer: capture / execute / scan / load result
    deqs_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    // ring store, pointers, search compare and output register
    deqs_datapath
    #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    )
    u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd       (cmd),
        .stat      (stat),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

endmodule
